// ===== rtl/wft_pkg.sv =====
// wft_pkg: shared types and constants of the word frequency table
// item structs, sequencer states, store command group, default sizes
// no dependencies
package wft_pkg;

   localparam int MAX_WORD_LEN_DEF  = 30;
   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int COUNT_BITS_DEF    = 32;

   localparam logic FUNC_TEXT = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

   typedef struct packed {
      logic       func;
      logic [7:0] char_byte;
      logic [7:0] entry_index;
      logic [4:0] char_pos;
   } req_type;

   typedef struct packed {
      logic [7:0]  word_entry;
      logic [31:0] word_count;
      logic        is_new;
      logic        table_full;
      logic        was_truncated;
      logic [7:0]  read_char;
      logic        entry_valid;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_INSERT,
      ST_READ
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_word;
      logic wr_count;
   } store_cmd_type;

endpackage

// ===== rtl/word_frequency_table_unit.sv =====
// word_frequency_table_unit: counts distinct words of a byte stream
// text byte: no result, the sequencer stays idle and ready for the next item
// word end: the scan compares one stored entry per cycle through the single read port,
// then updates the hit count or inserts the word while other requests stall
// read item: result registered from ST_READ; a stalled result holds the sequencer
// reset clears the word in progress and empties the table; depends on wft_pkg, wft_store
module word_frequency_table_unit #(
   parameter int MAX_WORD_LEN  = wft_pkg::MAX_WORD_LEN_DEF,
   parameter int TABLE_ENTRIES = wft_pkg::TABLE_ENTRIES_DEF,
   parameter int COUNT_BITS    = wft_pkg::COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wft_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wft_pkg::rsp_type rsp_item
);

   localparam int WORD_BITS = MAX_WORD_LEN * 8;
   localparam int LEN_W     = $clog2(MAX_WORD_LEN + 1);
   localparam int ADDR_W    = $clog2(TABLE_ENTRIES);
   localparam int USED_W    = $clog2(TABLE_ENTRIES + 1);

   wft_pkg::state_type     state_ff, state_in;
   logic [USED_W-1:0]      used_ff, used_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [WORD_BITS-1:0]   buf_ff, buf_in;
   logic                   ovf_ff, ovf_in;
   logic [USED_W-1:0]      issue_ff, issue_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [ADDR_W-1:0]      cmp_addr_ff, cmp_addr_in;
   logic [ADDR_W-1:0]      hit_entry_ff, hit_entry_in;
   logic [COUNT_BITS-1:0]  hit_count_ff, hit_count_in;
   logic [7:0]             rd_idx_ff, rd_idx_in;
   logic [4:0]             rd_pos_ff, rd_pos_in;
   logic                   rd_hit_ff, rd_hit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   wft_pkg::rsp_type       rsp_item_ff, rsp_item_in;

   wft_pkg::store_cmd_type cmd;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      wr_addr;
   logic [COUNT_BITS-1:0]  wr_count_data;
   logic [WORD_BITS-1:0]   rd_word;
   logic [LEN_W-1:0]       rd_len;
   logic [COUNT_BITS-1:0]  rd_count;

   logic                   accept;
   logic                   out_free;
   logic                   is_delim;
   logic                   hit;

   function automatic logic [31:0] clamp_count(input logic [COUNT_BITS-1:0] c);
      logic [63:0] w;
      w = 64'(c);
      return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

   function automatic logic [7:0] pick_char(input logic [WORD_BITS-1:0] w,
                                            input logic [7:0] p);
      logic [7:0] c;
      c = 8'h00;
      for (int i = 0; i < MAX_WORD_LEN; i++) begin
         if (p == 8'(i)) begin
            c = w[i*8 +: 8];
         end
      end
      return c;
   endfunction

   wft_store #(
      .MAX_WORD_LEN (MAX_WORD_LEN),
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .COUNT_BITS   (COUNT_BITS)
   ) u_store (
      .clock        (clock),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .wr_word_data (buf_ff),
      .wr_len       (len_ff),
      .wr_count_data(wr_count_data),
      .rd_word      (rd_word),
      .rd_len       (rd_len),
      .rd_count     (rd_count)
   );

   assign req_stall = (state_ff != wft_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_delim  = (req_item.char_byte == wft_pkg::CHAR_SPACE) ||
                      (req_item.char_byte == wft_pkg::CHAR_NEWLINE);
   // compare unit: whole word plus length against the scanned entry
   assign hit       = cmp_valid_ff && ({rd_len, rd_word} == {len_ff, buf_ff});

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      len_in        = len_ff;
      buf_in        = buf_ff;
      ovf_in        = ovf_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_addr_in   = cmp_addr_ff;
      hit_entry_in  = hit_entry_ff;
      hit_count_in  = hit_count_ff;
      rd_idx_in     = rd_idx_ff;
      rd_pos_in     = rd_pos_ff;
      rd_hit_in     = rd_hit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;
      cmd           = '0;
      rd_addr       = '0;
      wr_addr       = '0;
      wr_count_data = '0;

      case (state_ff)
         wft_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_item.func == wft_pkg::FUNC_READ) begin
                  cmd.rd_en = 1'b1;
                  rd_addr   = ADDR_W'(req_item.entry_index);
                  rd_idx_in = req_item.entry_index;
                  rd_pos_in = req_item.char_pos;
                  rd_hit_in = 16'(req_item.entry_index) < 16'(used_ff);
                  state_in  = wft_pkg::ST_READ;
               end else if (is_delim) begin
                  if (len_ff == '0) begin
                     ovf_in = 1'b0;
                  end else begin
                     issue_in     = '0;
                     cmp_valid_in = 1'b0;
                     state_in     = wft_pkg::ST_SCAN;
                  end
               end else if (32'(len_ff) < 32'(MAX_WORD_LEN)) begin
                  for (int i = 0; i < MAX_WORD_LEN; i++) begin
                     if (len_ff == LEN_W'(i)) begin
                        buf_in[i*8 +: 8] = req_item.char_byte;
                     end
                  end
                  len_in = len_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end

         wft_pkg::ST_SCAN: begin
            if (hit) begin
               hit_entry_in = cmp_addr_ff;
               hit_count_in = rd_count;
               cmp_valid_in = 1'b0;
               state_in     = wft_pkg::ST_UPDATE;
            end else if (issue_ff < used_ff) begin
               cmd.rd_en    = 1'b1;
               rd_addr      = issue_ff[ADDR_W-1:0];
               cmp_addr_in  = issue_ff[ADDR_W-1:0];
               cmp_valid_in = 1'b1;
               issue_in     = issue_ff + 1'b1;
            end else if (!cmp_valid_ff) begin
               state_in = wft_pkg::ST_INSERT;
            end else begin
               cmp_valid_in = 1'b0;
            end
         end

         wft_pkg::ST_UPDATE: begin
            if (out_free) begin
               cmd.wr_count  = 1'b1;
               wr_addr       = hit_entry_ff;
               wr_count_data = (hit_count_ff == '1) ? hit_count_ff
                                                    : hit_count_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_item_in   = '0;
               rsp_item_in.word_entry    = 8'(hit_entry_ff);
               rsp_item_in.word_count    = clamp_count(wr_count_data);
               rsp_item_in.was_truncated = ovf_ff;
               buf_in   = '0;
               len_in   = '0;
               ovf_in   = 1'b0;
               state_in = wft_pkg::ST_IDLE;
            end
         end

         wft_pkg::ST_INSERT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '0;
               rsp_item_in.was_truncated = ovf_ff;
               if (used_ff < USED_W'(TABLE_ENTRIES)) begin
                  cmd.wr_word   = 1'b1;
                  cmd.wr_count  = 1'b1;
                  wr_addr       = used_ff[ADDR_W-1:0];
                  wr_count_data = COUNT_BITS'(1);
                  used_in       = used_ff + 1'b1;
                  rsp_item_in.word_entry = 8'(used_ff);
                  rsp_item_in.word_count = 32'd1;
                  rsp_item_in.is_new     = 1'b1;
               end else begin
                  rsp_item_in.table_full = 1'b1;
               end
               buf_in   = '0;
               len_in   = '0;
               ovf_in   = 1'b0;
               state_in = wft_pkg::ST_IDLE;
            end
         end

         wft_pkg::ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '0;
               rsp_item_in.word_entry = rd_idx_ff;
               if (rd_hit_ff) begin
                  rsp_item_in.entry_valid = 1'b1;
                  rsp_item_in.word_count  = clamp_count(rd_count);
                  if (8'(rd_pos_ff) < 8'(rd_len)) begin
                     rsp_item_in.read_char = pick_char(rd_word, 8'(rd_pos_ff));
                  end
               end
               state_in = wft_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wft_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wft_pkg::ST_IDLE;
         used_ff      <= '0;
         len_ff       <= '0;
         buf_ff       <= '0;
         ovf_ff       <= 1'b0;
         issue_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         len_ff       <= len_in;
         buf_ff       <= buf_in;
         ovf_ff       <= ovf_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_addr_ff  <= cmp_addr_in;
      hit_entry_ff <= hit_entry_in;
      hit_count_ff <= hit_count_in;
      rd_idx_ff    <= rd_idx_in;
      rd_pos_ff    <= rd_pos_in;
      rd_hit_ff    <= rd_hit_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // table never grows past its depth
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(TABLE_ENTRIES))
      else $error("entry count beyond table depth");

   // word buffer never holds more than the maximum length
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      32'(len_ff) <= 32'(MAX_WORD_LEN))
      else $error("word length beyond maximum");

   // table grows by one entry at a time
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && used_ff != $past(used_ff)) |-> used_ff == $past(used_ff) + 1'b1)
      else $error("entry count jumped");

   // a newly inserted word always reports a count of one
   a_new_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.is_new) |-> rsp_item_ff.word_count == 32'd1)
      else $error("new entry with count other than one");

   // a full-table result only once every entry is in use
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.table_full) |-> used_ff == USED_W'(TABLE_ENTRIES))
      else $error("table full reported with free entries");

endmodule

// ===== rtl/wft_store.sv =====
// wft_store: entry storage of the word table, words with lengths and counts
// one write port and one registered read port per memory
// depends on wft_pkg
module wft_store #(
   parameter int MAX_WORD_LEN  = wft_pkg::MAX_WORD_LEN_DEF,
   parameter int TABLE_ENTRIES = wft_pkg::TABLE_ENTRIES_DEF,
   parameter int COUNT_BITS    = wft_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  wft_pkg::store_cmd_type        cmd,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  logic [MAX_WORD_LEN*8-1:0]     wr_word_data,
   input  logic [$clog2(MAX_WORD_LEN+1)-1:0] wr_len,
   input  logic [COUNT_BITS-1:0]         wr_count_data,
   output logic [MAX_WORD_LEN*8-1:0]     rd_word,
   output logic [$clog2(MAX_WORD_LEN+1)-1:0] rd_len,
   output logic [COUNT_BITS-1:0]         rd_count
);

   localparam int WORD_BITS = MAX_WORD_LEN * 8;
   localparam int LEN_W     = $clog2(MAX_WORD_LEN + 1);

   logic [WORD_BITS+LEN_W-1:0] word_mem_ff [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0]      count_mem_ff [TABLE_ENTRIES];
   logic [WORD_BITS+LEN_W-1:0] word_rd_ff;
   logic [COUNT_BITS-1:0]      count_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_word) begin
         word_mem_ff[wr_addr] <= {wr_len, wr_word_data};
      end
      if (cmd.rd_en) begin
         word_rd_ff <= word_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_count) begin
         count_mem_ff[wr_addr] <= wr_count_data;
      end
      if (cmd.rd_en) begin
         count_rd_ff <= count_mem_ff[rd_addr];
      end
   end

   assign rd_word  = word_rd_ff[WORD_BITS-1:0];
   assign rd_len   = word_rd_ff[WORD_BITS+LEN_W-1:WORD_BITS];
   assign rd_count = count_rd_ff;

endmodule

// ===== bench/word_frequency_table_unit_tb.sv =====
`timescale 1ns / 1ps
// word_frequency_table_unit_tb: self-checking bench for the word frequency table unit
// streams text and read items, predicts every result and checks it field by field
// depends on wft_pkg and word_frequency_table_unit
module word_frequency_table_unit_tb;

   localparam int WORD_MAX     = wft_pkg::MAX_WORD_LEN_DEF;
   localparam int ENTRIES      = wft_pkg::TABLE_ENTRIES_DEF;
   localparam int SPELL_MAX    = 40;
   localparam int VOCAB_SIZE   = 12;
   localparam int RANDOM_ITEMS = 80;
   localparam longint unsigned CYCLE_LIMIT = 2_000_000;
   localparam longint unsigned COUNT_TOP =
      64'hFFFF_FFFF_FFFF_FFFF >> (64 - wft_pkg::COUNT_BITS_DEF);

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   wft_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   wft_pkg::rsp_type rsp_item;

   logic [7:0]      word_chars [WORD_MAX];
   int unsigned     word_len = 0;
   bit              word_cut = 1'b0;
   logic [7:0]      table_chars [ENTRIES][WORD_MAX];
   int unsigned     table_len [ENTRIES];
   longint unsigned table_count [ENTRIES];
   int unsigned     table_used = 0;

   wft_pkg::req_type req_backlog [$];
   wft_pkg::rsp_type awaited_tallies [$];
   int unsigned     items_queued = 0;
   int unsigned     items_accepted = 0;
   int unsigned     mismatches = 0;
   longint unsigned cycle_count = 0;
   bit              req_taken = 1'b0;
   bit              rsp_taken = 1'b0;
   bit              calm_send = 1'b0;
   bit              calm_take = 1'b0;
   int              gap_left = 0;
   int              stall_left = 0;

   word_frequency_table_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] count_field(input longint unsigned count);
      return (count > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(count);
   endfunction

   function automatic bit tally_item(input wft_pkg::req_type it,
                                     output wft_pkg::rsp_type res);
      int hit;
      res = '0;
      if (it.func == wft_pkg::FUNC_READ) begin
         res.word_entry = it.entry_index;
         if (it.entry_index < table_used) begin
            res.entry_valid = 1'b1;
            res.word_count = count_field(table_count[it.entry_index]);
            if (it.char_pos < table_len[it.entry_index])
               res.read_char = table_chars[it.entry_index][it.char_pos];
         end
         return 1'b1;
      end
      if (it.char_byte != wft_pkg::CHAR_SPACE && it.char_byte != wft_pkg::CHAR_NEWLINE) begin
         if (word_len < WORD_MAX) begin
            word_chars[word_len] = it.char_byte;
            word_len++;
         end else begin
            word_cut = 1'b1;
         end
         return 1'b0;
      end
      if (word_len == 0) begin
         word_cut = 1'b0;
         return 1'b0;
      end
      res.was_truncated = word_cut;
      hit = -1;
      for (int e = 0; e < int'(table_used) && hit < 0; e++) begin
         if (table_len[e] == word_len) begin
            hit = e;
            for (int k = 0; k < int'(word_len); k++)
               if (table_chars[e][k] != word_chars[k]) hit = -1;
         end
      end
      if (hit >= 0) begin
         if (table_count[hit] < COUNT_TOP) table_count[hit]++;
         res.word_entry = 8'(hit);
         res.word_count = count_field(table_count[hit]);
      end else if (table_used < ENTRIES) begin
         table_chars[table_used] = word_chars;
         table_len[table_used] = word_len;
         table_count[table_used] = 1;
         res.word_entry = 8'(table_used);
         res.word_count = 32'd1;
         res.is_new = 1'b1;
         table_used++;
      end else begin
         res.table_full = 1'b1;
      end
      word_len = 0;
      word_cut = 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] word_byte();
      logic [7:0] ch;
      do ch = 8'($urandom);
      while (ch == wft_pkg::CHAR_SPACE || ch == wft_pkg::CHAR_NEWLINE);
      return ch;
   endfunction

   task automatic push_item(input wft_pkg::req_type it);
      req_backlog.push_back(it);
      items_queued++;
   endtask

   task automatic push_text(input logic [7:0] ch);
      wft_pkg::req_type it;
      it.func = wft_pkg::FUNC_TEXT;
      it.char_byte = ch;
      it.entry_index = 8'($urandom);
      it.char_pos = 5'($urandom);
      push_item(it);
   endtask

   task automatic push_read(input logic [7:0] idx, input logic [4:0] pos);
      wft_pkg::req_type it;
      it.func = wft_pkg::FUNC_READ;
      it.char_byte = 8'($urandom);
      it.entry_index = idx;
      it.char_pos = pos;
      push_item(it);
   endtask

   task automatic push_delim();
      push_text($urandom_range(0, 1) ? wft_pkg::CHAR_SPACE : wft_pkg::CHAR_NEWLINE);
   endtask

   task automatic push_any_read();
      logic [7:0] idx;
      logic [4:0] pos;
      idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      pos = $urandom_range(0, 1) ? 5'($urandom) : 5'($urandom_range(0, 7));
      push_read(idx, pos);
   endtask

   task automatic push_word(input logic [7:0] spell [SPELL_MAX], input int len);
      for (int k = 0; k < len; k++) begin
         push_text(spell[k]);
         if ($urandom_range(0, 19) == 0) push_any_read();
      end
      push_delim();
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (items_accepted != items_queued || awaited_tallies.size() != 0);
      @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input wft_pkg::rsp_type want,
                                  input wft_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s at cycle %0d", what, cycle_count);
         $display("  expected entry %0d count %0d new %b full %b cut %b char %h valid %b",
                  want.word_entry, want.word_count, want.is_new, want.table_full,
                  want.was_truncated, want.read_char, want.entry_valid);
         $display("  actual   entry %0d count %0d new %b full %b cut %b char %h valid %b",
                  got.word_entry, got.word_count, got.is_new, got.table_full,
                  got.was_truncated, got.read_char, got.entry_valid);
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_item <= req_backlog.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 39) == 0) calm_send = !calm_send;
            gap_left = calm_send ? 0 : $urandom_range(0, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         stall_left = 0;
      end else if (rsp_taken) begin
         if ($urandom_range(0, 39) == 0) calm_take = !calm_take;
         stall_left = calm_take ? 0 : $urandom_range(0, 17);
      end else if (rsp_valid && stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin
      wft_pkg::rsp_type want;
      wft_pkg::rsp_type fresh;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
         word_len = 0;
         word_cut = 1'b0;
         table_used = 0;
      end else if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         cycle_count++;
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            if (awaited_tallies.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_item);
            end else begin
               want = awaited_tallies.pop_front();
               if (want.word_entry !== rsp_item.word_entry ||
                   want.word_count !== rsp_item.word_count ||
                   want.is_new !== rsp_item.is_new ||
                   want.table_full !== rsp_item.table_full ||
                   want.was_truncated !== rsp_item.was_truncated ||
                   want.read_char !== rsp_item.read_char ||
                   want.entry_valid !== rsp_item.entry_valid)
                  report_mismatch("result mismatch", want, rsp_item);
            end
         end
         if (req_valid && !req_stall) begin
            items_accepted++;
            if (tally_item(req_item, fresh)) awaited_tallies.push_back(fresh);
         end
      end
   end

   initial begin
      logic [7:0]  spell [SPELL_MAX];
      logic [7:0]  last_fill [SPELL_MAX];
      logic [7:0]  long_base [SPELL_MAX];
      logic [7:0]  vocab [VOCAB_SIZE][SPELL_MAX];
      int          vocab_len [VOCAB_SIZE];
      int          pick;
      int          r;
      int          fill_id;
      int          fill_len;
      int          last_fill_len;
      int unsigned start;
      bit          reuse;
      bit          clash;

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // empty table, empty word, zero and all-ones bytes, prefix word, read mid-word
      push_read(8'd0, 5'd0);
      push_text(wft_pkg::CHAR_SPACE);
      push_text(8'h00);
      push_text(8'hff);
      push_text(8'h41);
      push_text(wft_pkg::CHAR_NEWLINE);
      push_text(8'h00);
      push_text(8'hff);
      push_text(8'h41);
      push_text(wft_pkg::CHAR_SPACE);
      push_text(8'h00);
      push_text(wft_pkg::CHAR_SPACE);
      push_text(wft_pkg::CHAR_NEWLINE);
      push_text(8'h7f);
      push_read(8'd1, 5'd0);
      push_text(8'h80);
      push_text(wft_pkg::CHAR_NEWLINE);
      push_read(8'd0, 5'd0);
      push_read(8'd0, 5'd1);
      push_read(8'd0, 5'd2);
      push_read(8'd0, 5'd3);
      push_read(8'd0, 5'd31);
      push_read(8'd2, 5'd1);
      push_read(8'd255, 5'd31);

      foreach (long_base[k]) long_base[k] = word_byte();
      for (int v = 0; v < VOCAB_SIZE; v++) begin
         vocab_len[v] = $urandom_range(1, 6);
         foreach (spell[k]) vocab[v][k] = word_byte();
         // every third word is a prefix of the word before it, where that word is longer than one byte
         if (v % 3 == 1 && vocab_len[v - 1] > 1) begin
            vocab[v] = vocab[v - 1];
            vocab_len[v] = vocab_len[v - 1] - 1;
         end
      end

      start = items_queued;
      for (int half = 1; half <= 2; half++) begin
         while (items_queued - start < half * RANDOM_ITEMS / 2) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               r = $urandom_range(0, VOCAB_SIZE - 1);
               push_word(vocab[r], vocab_len[r]);
            end else if (pick < 62) begin
               foreach (spell[k]) spell[k] = word_byte();
               push_word(spell, $urandom_range(1, 8));
            end else if (pick < 70) begin
               reuse = $urandom_range(0, 1);
               foreach (spell[k]) spell[k] = (reuse && k < WORD_MAX) ? long_base[k] : word_byte();
               push_word(spell, $urandom_range(WORD_MAX - 1, WORD_MAX + 4));
            end else if (pick < 75) begin
               push_delim();
            end else begin
               push_any_read();
            end
         end
         if (half == 1) wait_drained();
      end

      // fill the table with short words known to be distinct
      wait_drained();
      fill_id = 0;
      fill_len = 1;
      foreach (spell[k]) spell[k] = word_byte();
      repeat (ENTRIES - table_used) begin
         do begin
            fill_len = (fill_id < 256) ? 1 : 2;
            spell[0] = (fill_id < 256) ? 8'(fill_id) : 8'hf1;
            spell[1] = 8'(fill_id);
            fill_id++;
            clash = (spell[fill_len - 1] == wft_pkg::CHAR_SPACE ||
                     spell[fill_len - 1] == wft_pkg::CHAR_NEWLINE);
            for (int e = 0; e < int'(table_used); e++)
               if (table_len[e] == fill_len && table_chars[e][0] == spell[0] &&
                   (fill_len == 1 || table_chars[e][1] == spell[1]))
                  clash = 1'b1;
         end while (clash);
         push_word(spell, fill_len);
      end
      last_fill = spell;
      last_fill_len = fill_len;

      // full table: new words are refused, known ones still count
      for (int n = 0; n < 6; n++) begin
         foreach (spell[k]) spell[k] = word_byte();
         push_word(spell, $urandom_range(1, 8));
      end
      foreach (spell[k]) spell[k] = word_byte();
      push_word(spell, WORD_MAX + 3);
      push_word(last_fill, last_fill_len);
      for (int n = 0; n < 6; n++) begin
         r = $urandom_range(0, VOCAB_SIZE - 1);
         push_word(vocab[r], vocab_len[r]);
      end
      push_read(8'd255, 5'd0);
      push_read(8'd255, 5'd1);
      push_read(8'd255, 5'd2);
      push_read(8'd255, 5'd3);
      push_read(8'd255, 5'd31);
      repeat (10) push_any_read();

      wait_drained();
      repeat (ENTRIES + 40) @(negedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/wft_pkg.sv
rtl/wft_store.sv
rtl/word_frequency_table_unit.sv
bench/word_frequency_table_unit_tb.sv
